// ===== hdl/slse_pkg.sv =====
// Package for the streaming log-sum-exp block: codes, command and status types,
// and the constant functions that build the exp and log interpolation tables.
// Used by slse_dp, slse_ctrl, the top and the testbench; depends on nothing.
package slse_pkg;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int SUM_INT_BITS_DEF    = 16;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int SUM_W = 48;
    localparam int TAB_W = 31;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam logic [1:0] KIND_FINITE  = 2'd0;
    localparam logic [1:0] KIND_POS_INF = 2'd1;

    localparam logic [1:0] STAT_EMPTY  = 2'd0;
    localparam logic [1:0] STAT_FINITE = 2'd1;
    localparam logic [1:0] STAT_INF    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DECIDE,
        OP_EXP_T,
        OP_IDX,
        OP_TAB,
        OP_INTERP,
        OP_SCALE_HI,
        OP_SCALE_LO,
        OP_UPDATE,
        OP_NORM,
        OP_LOG_IP,
        OP_LN_MUL,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       use_log;
        logic [1:0] norm_step;
    } dp_cmd_t;

    typedef struct packed {
        logic need_exp;
        logic gt;
        logic log_next;
        logic out_free;
    } dp_status_t;

    // Restoring long division, used only while the tables are elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], a[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i of the 2^(-i/n) table in Q30, from a 25-term series of exp(-y).
    function automatic logic [TAB_W-1:0] exp_entry(input logic [63:0] i, input logic [63:0] n);
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] acc;
        y    = udiv64(i * 64'd744261118, n);
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if ((k % 2) == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        return acc[TAB_W-1:0];
    endfunction

    // Entry i of the log2(1 + i/n) table in Q30, by repeated squaring.
    function automatic logic [TAB_W-1:0] log_entry(input logic [63:0] i, input logic [63:0] n);
        logic [63:0] x;
        logic [63:0] r;
        x = udiv64((n + i) << 30, n);
        r = '0;
        if (x >= (64'd1 << 31)) begin
            r = 64'd1 << 30;
        end
        else begin
            for (int b = 29; b >= 0; b--) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    r[b] = 1'b1;
                end
            end
        end
        return r[TAB_W-1:0];
    endfunction

endpackage

// ===== hdl/slse_in_if.sv =====
// Input channel of the streaming log-sum-exp block: valid/ready and the sample.
// Depends on nothing.
interface slse_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic [1:0]  sample_kind;
    logic        restart;

    modport source(output valid, sample, sample_kind, restart, input ready);
    modport sink(input valid, sample, sample_kind, restart, output ready);
endinterface

// ===== hdl/slse_out_if.sv =====
// Output channel of the streaming log-sum-exp block: valid/ready and the result.
// Depends on nothing.
interface slse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] lse_result;
    logic [31:0] running_peak;
    logic [1:0]  result_status;

    modport source(output valid, lse_result, running_peak, result_status, input ready);
    modport sink(input valid, lse_result, running_peak, result_status, output ready);
endinterface

// ===== hdl/slse_dp.sv =====
// Datapath of the streaming log-sum-exp block: accumulator state, the exp and
// log table interpolation, normalization, rescale and the output register.
// Depends on slse_pkg; driven by commands from slse_ctrl.
module slse_dp #(
    parameter int FRAC_BITS       = slse_pkg::FRAC_BITS_DEF,
    parameter int SUM_INT_BITS    = slse_pkg::SUM_INT_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = slse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slse_pkg::dp_cmd_t    cmd,
    output slse_pkg::dp_status_t status,
    input  logic [31:0]          sample,
    input  logic [1:0]           sample_kind,
    input  logic                 restart,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [31:0]          lse_result,
    output logic [31:0]          running_peak,
    output logic [1:0]           result_status
);
    localparam int SW       = slse_pkg::SUM_W;
    localparam int TW       = slse_pkg::TAB_W;
    localparam int SUM_FRAC = SW - SUM_INT_BITS;
    localparam int SHL      = SUM_FRAC - 30;
    localparam int SHL_L    = (SHL > 0) ? SHL : 0;
    localparam int SHR_R    = (SHL < 0) ? -SHL : 0;
    localparam int IDXW     = $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [SW-1:0] SUM_ONE = SW'(1) << SUM_FRAC;
    localparam logic [SW-1:0] SUM_MAX = '1;
    localparam logic [31:0]   NEG_MAX = 32'h8000_0000;
    localparam logic [31:0]   POS_MAX = 32'h7FFF_FFFF;

    logic [TW-1:0] exp_tab [0:EXP_TABLE_DEPTH];
    logic [TW-1:0] log_tab [0:EXP_TABLE_DEPTH];

    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
        assign exp_tab[gi] = slse_pkg::exp_entry(64'(gi), 64'(EXP_TABLE_DEPTH));
        assign log_tab[gi] = slse_pkg::log_entry(64'(gi), 64'(EXP_TABLE_DEPTH));
    end

    logic [31:0]     v_reg;
    logic [1:0]      kind_reg;
    logic [31:0]     peak_reg, peak_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [1:0]      stat_reg, stat_next;
    logic [31:0]     d_reg, d_next;
    logic            gt_reg, gt_next;
    logic [5:0]      sh_reg, sh_next;
    logic            shbig_reg, shbig_next;
    logic [29:0]     frac_reg, frac_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [29:0]     rem_reg, rem_next;
    logic [TW-1:0]   a_reg, a_next;
    logic [TW-1:0]   diff_reg, diff_next;
    logic [TW-1:0]   mant_reg, mant_next;
    logic [55:0]     p_reg, p_next;
    logic [SW-1:0]   norm_reg, norm_next;
    logic [5:0]      lz_reg, lz_next;
    logic [5:0]      ip_reg, ip_next;
    logic [6:0]      lghi_reg, lghi_next;
    logic [29:0]     q_reg, q_next;
    logic            ov_reg, ov_next;
    logic [31:0]     lse_reg, lse_next;
    logic [31:0]     pk_out_reg, pk_out_next;
    logic [1:0]      st_out_reg, st_out_next;

    logic            out_free;
    logic            v_gt;
    logic [1:0]      stat_after;

    assign out_free = !ov_reg || out_ready;
    assign v_gt     = $signed(v_reg) > $signed(peak_reg);

    always_comb
    begin
        if (kind_reg == slse_pkg::KIND_POS_INF)
            stat_after = slse_pkg::STAT_INF;
        else if (kind_reg == slse_pkg::KIND_FINITE && stat_reg == slse_pkg::STAT_EMPTY)
            stat_after = slse_pkg::STAT_FINITE;
        else
            stat_after = stat_reg;
    end

    assign status.need_exp = (kind_reg == slse_pkg::KIND_FINITE)
                             && (stat_reg == slse_pkg::STAT_FINITE);
    assign status.gt       = gt_reg;
    assign status.log_next = (stat_after == slse_pkg::STAT_FINITE);
    assign status.out_free = out_free;

    always_comb
    begin
        logic [62:0]           tprod;
        logic [62:0]           t;
        logic [29+IDXW:0]      pos;
        logic [IDXW-1:0]       idx1;
        logic [TW-1:0]         ta, tb;
        logic [60:0]           dr_full;
        logic [TW-1:0]         dr;
        logic [54:0]           lo_prod;
        logic [49:0]           q;
        logic [50:0]           tot_gt;
        logic [SW:0]           term;
        logic [SW:0]           tot_le;
        logic [SW-1:0]         s;
        logic [5:0]            lz;
        logic [5:0]            amt;
        logic [36:0]           lg;
        logic [59:0]           lq;
        logic [36:0]           ln;
        logic [36:0]           lnf;
        logic signed [38:0]    r;

        peak_next   = peak_reg;
        sum_next    = sum_reg;
        stat_next   = stat_reg;
        d_next      = d_reg;
        gt_next     = gt_reg;
        sh_next     = sh_reg;
        shbig_next  = shbig_reg;
        frac_next   = frac_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        a_next      = a_reg;
        diff_next   = diff_reg;
        mant_next   = mant_reg;
        p_next      = p_reg;
        norm_next   = norm_reg;
        lz_next     = lz_reg;
        ip_next     = ip_reg;
        lghi_next   = lghi_reg;
        q_next      = q_reg;
        ov_next     = ov_reg && !out_ready;
        lse_next    = lse_reg;
        pk_out_next = pk_out_reg;
        st_out_next = st_out_reg;

        tprod   = '0;
        t       = '0;
        pos     = '0;
        idx1    = '0;
        ta      = '0;
        tb      = '0;
        dr_full = '0;
        dr      = '0;
        lo_prod = '0;
        q       = '0;
        tot_gt  = '0;
        term    = '0;
        tot_le  = '0;
        s       = '0;
        lz      = '0;
        amt     = '0;
        lg      = '0;
        lq      = '0;
        ln      = '0;
        lnf     = '0;
        r       = '0;

        unique case (cmd.op)
            slse_pkg::OP_CAPTURE:
            begin
                if (restart)
                begin
                    peak_next = NEG_MAX;
                    sum_next  = '0;
                    stat_next = slse_pkg::STAT_EMPTY;
                end
            end
            slse_pkg::OP_DECIDE:
            begin
                stat_next = stat_after;
                gt_next   = v_gt;
                if (v_gt)
                    d_next = v_reg - peak_reg;
                else
                    d_next = peak_reg - v_reg;
                if (kind_reg == slse_pkg::KIND_FINITE && stat_reg == slse_pkg::STAT_EMPTY)
                begin
                    sum_next  = SUM_ONE;
                    peak_next = v_reg;
                end
            end
            slse_pkg::OP_EXP_T:
            begin
                // t = d * log2(e) in Q30; its integer part is the shift.
                tprod      = 63'(d_reg) * 63'(slse_pkg::LOG2E_Q30);
                t          = tprod >> FRAC_BITS;
                sh_next    = t[35:30];
                shbig_next = (t >> 30) >= 63'd63;
                frac_next  = t[29:0];
            end
            slse_pkg::OP_IDX:
            begin
                pos      = (30+IDXW)'(frac_reg) * (30+IDXW)'(EXP_TABLE_DEPTH);
                idx_next = pos[29+IDXW:30];
                rem_next = pos[29:0];
            end
            slse_pkg::OP_TAB:
            begin
                idx1 = idx_reg + 1'b1;
                if (cmd.use_log)
                begin
                    ta = log_tab[idx_reg];
                    tb = log_tab[idx1];
                    diff_next = (tb > ta) ? tb - ta : '0;
                end
                else
                begin
                    ta = exp_tab[idx_reg];
                    tb = exp_tab[idx1];
                    diff_next = (ta > tb) ? ta - tb : '0;
                end
                a_next = ta;
            end
            slse_pkg::OP_INTERP:
            begin
                dr_full = 61'(diff_reg) * 61'(rem_reg);
                dr      = dr_full[30+TW-1:30];
                mant_next = cmd.use_log ? a_reg + dr : a_reg - dr;
            end
            slse_pkg::OP_SCALE_HI:
            begin
                p_next = 56'(sum_reg[47:24]) * 56'(mant_reg);
            end
            slse_pkg::OP_SCALE_LO:
            begin
                lo_prod = 55'(sum_reg[23:0]) * 55'(mant_reg);
                p_next  = p_reg + 56'(lo_prod >> 24);
            end
            slse_pkg::OP_UPDATE:
            begin
                if (gt_reg)
                begin
                    // New peak: old sum scaled by exp(old peak - value), plus one.
                    q      = shbig_reg ? '0 : (p_reg[55:6] >> sh_reg);
                    tot_gt = 51'(q) + 51'(SUM_ONE);
                    sum_next  = (tot_gt > 51'(SUM_MAX)) ? SUM_MAX : tot_gt[SW-1:0];
                    peak_next = v_reg;
                end
                else
                begin
                    term   = ((SW+1)'(mant_reg) << SHL_L) >> SHR_R;
                    term   = shbig_reg ? '0 : (term >> sh_reg);
                    tot_le = {1'b0, sum_reg} + term;
                    sum_next = tot_le[SW] ? SUM_MAX : tot_le[SW-1:0];
                end
            end
            slse_pkg::OP_NORM:
            begin
                // Leading-zero search, two binary steps per cycle.
                if (cmd.norm_step == 2'd0)
                begin
                    s  = (sum_reg < SUM_ONE) ? SUM_ONE : sum_reg;
                    lz = '0;
                end
                else
                begin
                    s  = norm_reg;
                    lz = lz_reg;
                end
                for (int j = 0; j < 2; j++)
                begin
                    amt = 6'd32 >> (6'(cmd.norm_step) * 6'd2 + 6'(j));
                    if ((s >> (7'd48 - 7'(amt))) == '0)
                    begin
                        s  = s << amt;
                        lz = lz + amt;
                    end
                end
                norm_next = s;
                lz_next   = lz;
            end
            slse_pkg::OP_LOG_IP:
            begin
                ip_next   = 6'(47 - SUM_FRAC) - lz_reg;
                frac_next = norm_reg[46:17];
            end
            slse_pkg::OP_LN_MUL:
            begin
                lg        = {1'b0, ip_reg, 30'd0} + 37'(mant_reg);
                lghi_next = lg[36:30];
                lq        = 60'(lg[29:0]) * 60'(slse_pkg::LN2_Q30);
                q_next    = lq[59:30];
            end
            slse_pkg::OP_FINISH:
            begin
                ln  = 37'(lghi_reg) * 37'(slse_pkg::LN2_Q30) + 37'(q_reg);
                lnf = ln >> (30 - FRAC_BITS);
                r   = 39'($signed(peak_reg)) + $signed({2'b00, lnf});
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    pk_out_next = peak_reg;
                    st_out_next = stat_reg;
                    if (stat_reg == slse_pkg::STAT_EMPTY)
                        lse_next = NEG_MAX;
                    else if (stat_reg == slse_pkg::STAT_INF)
                        lse_next = POS_MAX;
                    else if (r > 39'sd2147483647)
                        lse_next = POS_MAX;
                    else
                        lse_next = r[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= NEG_MAX;
            sum_reg  <= '0;
            stat_reg <= slse_pkg::STAT_EMPTY;
            ov_reg   <= 1'b0;
        end
        else
        begin
            peak_reg <= peak_next;
            sum_reg  <= sum_next;
            stat_reg <= stat_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == slse_pkg::OP_CAPTURE)
        begin
            v_reg    <= sample;
            kind_reg <= sample_kind;
        end
        d_reg      <= d_next;
        gt_reg     <= gt_next;
        sh_reg     <= sh_next;
        shbig_reg  <= shbig_next;
        frac_reg   <= frac_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        a_reg      <= a_next;
        diff_reg   <= diff_next;
        mant_reg   <= mant_next;
        p_reg      <= p_next;
        norm_reg   <= norm_next;
        lz_reg     <= lz_next;
        ip_reg     <= ip_next;
        lghi_reg   <= lghi_next;
        q_reg      <= q_next;
        lse_reg    <= lse_next;
        pk_out_reg <= pk_out_next;
        st_out_reg <= st_out_next;
    end

    assign out_valid     = ov_reg;
    assign lse_result    = lse_reg;
    assign running_peak  = pk_out_reg;
    assign result_status = st_out_reg;

endmodule

// ===== hdl/slse_ctrl.sv =====
// Controller of the streaming log-sum-exp block: steps the datapath through
// decide, exp interpolation, rescale, normalization, log and finish.
// Depends on slse_pkg.
module slse_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  slse_pkg::dp_status_t status,
    output slse_pkg::dp_cmd_t    cmd
);
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECIDE = 13'b0000000000010,
        S_EXPT   = 13'b0000000000100,
        S_IDX    = 13'b0000000001000,
        S_TAB    = 13'b0000000010000,
        S_INTERP = 13'b0000000100000,
        S_SCHI   = 13'b0000001000000,
        S_SCLO   = 13'b0000010000000,
        S_UPD    = 13'b0000100000000,
        S_NORM   = 13'b0001000000000,
        S_LOGIP  = 13'b0010000000000,
        S_LNMUL  = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       log_reg, log_next;
    logic [1:0] step_reg, step_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.use_log   = log_reg;
    assign cmd.norm_step = step_reg;

    always_comb
    begin
        state_next = state_reg;
        log_next   = log_reg;
        step_next  = step_reg;
        cmd.op     = slse_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = slse_pkg::OP_CAPTURE;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.op    = slse_pkg::OP_DECIDE;
                log_next  = 1'b0;
                step_next = 2'd0;
                if (status.need_exp)
                    state_next = S_EXPT;
                else if (status.log_next)
                begin
                    log_next   = 1'b1;
                    state_next = S_NORM;
                end
                else
                    state_next = S_FIN;
            end
            S_EXPT:
            begin
                cmd.op     = slse_pkg::OP_EXP_T;
                state_next = S_IDX;
            end
            S_IDX:
            begin
                cmd.op     = slse_pkg::OP_IDX;
                state_next = S_TAB;
            end
            S_TAB:
            begin
                cmd.op     = slse_pkg::OP_TAB;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.op = slse_pkg::OP_INTERP;
                if (log_reg)
                    state_next = S_LNMUL;
                else if (status.gt)
                    state_next = S_SCHI;
                else
                    state_next = S_UPD;
            end
            S_SCHI:
            begin
                cmd.op     = slse_pkg::OP_SCALE_HI;
                state_next = S_SCLO;
            end
            S_SCLO:
            begin
                cmd.op     = slse_pkg::OP_SCALE_LO;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = slse_pkg::OP_UPDATE;
                log_next   = 1'b1;
                step_next  = 2'd0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op = slse_pkg::OP_NORM;
                if (step_reg == 2'd2)
                    state_next = S_LOGIP;
                else
                    step_next = step_reg + 2'd1;
            end
            S_LOGIP:
            begin
                cmd.op     = slse_pkg::OP_LOG_IP;
                state_next = S_IDX;
            end
            S_LNMUL:
            begin
                cmd.op     = slse_pkg::OP_LN_MUL;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Holds here while the previous result still waits at the output.
                cmd.op = slse_pkg::OP_FINISH;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            log_reg   <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            log_reg   <= log_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hdl/streaming_log_sum_exp_top.sv =====
// Streaming log-sum-exp, one result request per input request.
// No new input is taken until the last item's result is registered at the output.
// A result still waiting at the output holds the finish step until it is taken.
// Exp interpolation, normalization and log interpolation run in sequence; the exp and
// log interpolations share one table unit. Reset (rst_n, async) empties the state.
module streaming_log_sum_exp_top #(
    parameter int FRAC_BITS       = slse_pkg::FRAC_BITS_DEF,
    parameter int SUM_INT_BITS    = slse_pkg::SUM_INT_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = slse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    slse_in_if.sink   in_ch,
    slse_out_if.source out_ch
);
    slse_pkg::dp_cmd_t    cmd;
    slse_pkg::dp_status_t status;

    slse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    slse_dp #(
        .FRAC_BITS       (FRAC_BITS),
        .SUM_INT_BITS    (SUM_INT_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (in_ch.sample),
        .sample_kind   (in_ch.sample_kind),
        .restart       (in_ch.restart),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .lse_result    (out_ch.lse_result),
        .running_peak  (out_ch.running_peak),
        .result_status (out_ch.result_status)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while an item is in progress");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.result_status == slse_pkg::STAT_EMPTY)
        |-> (out_ch.lse_result == 32'h8000_0000 && out_ch.running_peak == 32'h8000_0000))
        else $error("empty result is not minus infinity");

    a_inf_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.result_status == slse_pkg::STAT_INF)
        |-> out_ch.lse_result == 32'h7FFF_FFFF)
        else $error("infinite result is not saturated high");

    a_finite_above_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.result_status == slse_pkg::STAT_FINITE)
        |-> $signed(out_ch.lse_result) >= $signed(out_ch.running_peak))
        else $error("finite log-sum-exp below the running peak");

endmodule

// ===== verif/tb_streaming_log_sum_exp_top.sv =====
// Self-checking testbench for streaming_log_sum_exp_top: directed table, then random
// accumulation runs, checked against a fixed-point log-sum-exp predictor kept here.
// Depends on slse_pkg, slse_in_if, slse_out_if and the block itself.
`timescale 1ns / 100ps

module tb_streaming_log_sum_exp_top;

    localparam logic [1:0] KIND_NEG_INF = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam int          TAB_N     = 256;
    localparam int          SUM_FRACB = 32;
    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] MASK_Q30  = ONE_Q30 - 64'd1;
    localparam logic [63:0] LN2_C     = 64'd744261118;
    localparam logic [63:0] LOG2E_C   = 64'd1549082005;
    localparam logic [63:0] SUM_UNIT  = 64'd1 << SUM_FRACB;
    localparam logic [63:0] SUM_SAT   = (64'd1 << 48) - 64'd1;
    localparam int          RANDOM_ITEMS = 1430;

    typedef struct packed {
        logic [31:0] lse;
        logic [31:0] peak;
        logic [1:0]  status;
    } lse_result_t;

    typedef struct {
        logic [31:0] sample;
        logic [1:0]  kind;
        logic        restart;
        logic        known;
        lse_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   errors;

    slse_in_if  in_ch();
    slse_out_if out_ch();

    streaming_log_sum_exp_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // Predictor state and tables.
    logic [63:0] pow2_tab [0:TAB_N];
    logic [63:0] lg2_tab [0:TAB_N];
    logic signed [31:0] model_peak;
    logic [63:0]        model_sum;
    logic [1:0]         model_status;

    lse_result_t pending_results[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic build_tables();
        logic [63:0] y;
        logic [63:0] term;
        logic signed [63:0] acc;
        logic [63:0] x;
        logic [63:0] r;
        for (int i = 0; i <= TAB_N; i++)
        begin
            y    = (64'(i) * LN2_C) / 64'(TAB_N);
            term = ONE_Q30;
            acc  = $signed(ONE_Q30);
            for (int k = 1; k <= 24; k++)
            begin
                term = ((term * y) >> 30) / 64'(k);
                if (k % 2 == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            if (acc < 0)
                acc = 0;
            pow2_tab[i] = acc;
            x = (64'(TAB_N + i) << 30) / 64'(TAB_N);
            r = 64'd0;
            if (x >= (ONE_Q30 << 1))
            begin
                r = ONE_Q30;
            end
            else
            begin
                for (int b = 29; b >= 0; b--)
                begin
                    x = (x * x) >> 30;
                    if (x >= (ONE_Q30 << 1))
                    begin
                        x = x >> 1;
                        r[b] = 1'b1;
                    end
                end
            end
            lg2_tab[i] = r;
        end
    endtask

    // exp(-d) as a Q30 mantissa and a right shift, d in Q16.16.
    task automatic exp_of_neg(input logic [63:0] d, output logic [63:0] mant,
                              output logic [63:0] sh);
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] diff;
        t    = (d * LOG2E_C) >> 16;
        sh   = t >> 30;
        pos  = (t & MASK_Q30) * 64'(TAB_N);
        idx  = pos >> 30;
        rem  = pos & MASK_Q30;
        a    = pow2_tab[idx];
        b    = pow2_tab[idx + 1];
        diff = (a > b) ? a - b : 64'd0;
        mant = a - ((diff * rem) >> 30);
    endtask

    function automatic logic [63:0] ln_of_sum(input logic [63:0] s);
        int          p;
        logic [63:0] norm;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] diff;
        logic [63:0] lg;
        logic [63:0] ln;
        p = 47;
        while (p > 0 && s[p] == 1'b0)
            p--;
        norm = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
        pos  = ((norm - ONE_Q30) & MASK_Q30) * 64'(TAB_N);
        idx  = pos >> 30;
        rem  = pos & MASK_Q30;
        a    = lg2_tab[idx];
        b    = lg2_tab[idx + 1];
        diff = (b > a) ? b - a : 64'd0;
        lg   = (64'(p - SUM_FRACB) << 30) + a + ((diff * rem) >> 30);
        ln   = (lg >> 30) * LN2_C + (((lg & MASK_Q30) * LN2_C) >> 30);
        return ln >> 14;
    endfunction

    task automatic predict_lse(input logic [31:0] sample, input logic [1:0] kind,
                               input logic restart, output lse_result_t res);
        logic [63:0] mant;
        logic [63:0] sh;
        logic [63:0] term;
        logic [63:0] prod;
        logic [63:0] s;
        logic signed [63:0] v;
        logic signed [63:0] pk;
        logic signed [63:0] r;
        v = $signed(sample);
        if (restart)
        begin
            model_peak   = 32'sh8000_0000;
            model_sum    = 64'd0;
            model_status = slse_pkg::STAT_EMPTY;
        end
        pk = model_peak;
        if (kind == slse_pkg::KIND_POS_INF)
        begin
            model_status = slse_pkg::STAT_INF;
        end
        else if (kind == slse_pkg::KIND_FINITE && model_status != slse_pkg::STAT_INF)
        begin
            if (model_status == slse_pkg::STAT_EMPTY)
            begin
                model_sum    = SUM_UNIT;
                model_peak   = sample;
                model_status = slse_pkg::STAT_FINITE;
            end
            else if (v <= pk)
            begin
                exp_of_neg(64'(pk - v), mant, sh);
                term      = mant << (SUM_FRACB - 30);
                term      = (sh < 63) ? (term >> sh) : 64'd0;
                model_sum = model_sum + term;
                if (model_sum > SUM_SAT)
                    model_sum = SUM_SAT;
            end
            else
            begin
                exp_of_neg(64'(v - pk), mant, sh);
                prod = ((model_sum >> 24) * mant + (((model_sum & 64'hFF_FFFF) * mant) >> 24))
                       >> 6;
                prod = (sh < 63) ? (prod >> sh) : 64'd0;
                model_sum = prod + SUM_UNIT;
                if (model_sum > SUM_SAT)
                    model_sum = SUM_SAT;
                model_peak = sample;
            end
        end
        res.peak   = model_peak;
        res.status = model_status;
        if (model_status == slse_pkg::STAT_EMPTY)
        begin
            res.lse = 32'h8000_0000;
        end
        else if (model_status == slse_pkg::STAT_INF)
        begin
            res.lse = 32'h7FFF_FFFF;
        end
        else
        begin
            s = (model_sum < SUM_UNIT) ? SUM_UNIT : model_sum;
            r = 64'(model_peak) + $signed(ln_of_sum(s));
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            res.lse = r[31:0];
        end
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic [31:0] sample, input logic [1:0] kind,
                                input logic restart, input logic known,
                                input lse_result_t want);
        lse_result_t predicted;
        int          gap;
        in_ch.sample      = sample;
        in_ch.sample_kind = kind;
        in_ch.restart     = restart;
        in_ch.valid       = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_lse(sample, kind, restart, predicted);
        pending_results.push_back(known ? want : predicted);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    function automatic logic [31:0] random_sample(input logic signed [31:0] peak);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return peak - 32'($urandom_range(0, 32'h000A_0000));
        if (r < 70)
            return peak + 32'($urandom_range(0, 32'h0004_0000));
        if (r < 80)
            return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        return $urandom;
    endfunction

    // Result side: random back-pressure, checked at the rising edge.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < 8)
            begin
                out_ch.ready = 1'b0;
                repeat (pick_gap())
                    @(negedge clk);
            end
            out_ch.ready = ($urandom_range(0, 99) < 85) || (pick_gap() == 0);
        end
    end

    always @(posedge clk)
    begin
        lse_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result lse=%h peak=%h status=%0d", $time,
                         out_ch.lse_result, out_ch.running_peak, out_ch.result_status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.lse_result !== want.lse)
                begin
                    $display("%0t: lse_result expected %h actual %h", $time, want.lse,
                             out_ch.lse_result);
                    errors++;
                end
                if (out_ch.running_peak !== want.peak)
                begin
                    $display("%0t: running_peak expected %h actual %h", $time, want.peak,
                             out_ch.running_peak);
                    errors++;
                end
                if (out_ch.result_status !== want.status)
                begin
                    $display("%0t: result_status expected %0d actual %0d", $time,
                             want.status, out_ch.result_status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t          rows[$];
        stim_row_t          row;
        lse_result_t        none;
        logic [1:0]         kind;
        logic               restart;
        int                 r;
        int                 waited;
        errors            = 0;
        none              = '0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.sample_kind = slse_pkg::KIND_FINITE;
        in_ch.restart     = 1'b0;
        model_peak        = 32'sh8000_0000;
        model_sum         = 64'd0;
        model_status      = slse_pkg::STAT_EMPTY;
        build_tables();

        // Directed rows: the known column holds results readable straight off the rules.
        rows = '{
            '{32'h0000_0000, KIND_NEG_INF, 1'b0, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, slse_pkg::STAT_EMPTY}},
            '{32'h1234_5678, KIND_UNUSED,  1'b0, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, slse_pkg::STAT_EMPTY}},
            '{32'h0000_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b1,
              '{32'h0000_0000, 32'h0000_0000, slse_pkg::STAT_FINITE}},
            '{32'h0000_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'hFFFF_8000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h0001_8000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h8000_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h0000_0000, KIND_NEG_INF, 1'b0, 1'b0, none},
            '{32'h7FFF_FFFF, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h7FFF_FFFF, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h7FFF_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h0000_0000, slse_pkg::KIND_POS_INF, 1'b0, 1'b1,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, slse_pkg::STAT_INF}},
            '{32'h0000_1000, slse_pkg::KIND_FINITE,  1'b0, 1'b1,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, slse_pkg::STAT_INF}},
            '{32'h0000_1000, KIND_NEG_INF, 1'b0, 1'b1,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, slse_pkg::STAT_INF}},
            '{32'h0000_0000, KIND_NEG_INF, 1'b1, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, slse_pkg::STAT_EMPTY}},
            '{32'h8000_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, slse_pkg::STAT_FINITE}},
            '{32'h8000_0000, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h7FFF_FFFF, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h0000_0000, slse_pkg::KIND_POS_INF, 1'b1, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, slse_pkg::STAT_INF}},
            '{32'hFFFF_FFFF, slse_pkg::KIND_FINITE,  1'b1, 1'b1,
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, slse_pkg::STAT_FINITE}},
            '{32'h0000_0001, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'hFFFF_FFFF, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none},
            '{32'h5555_AAAA, KIND_UNUSED,  1'b0, 1'b0, none},
            '{32'hAAAA_5555, slse_pkg::KIND_FINITE,  1'b0, 1'b0, none}
        };

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_request(row.sample, row.kind, row.restart, row.known, row.want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Let the block drain once, mid-run, before carrying on.
            if (n == RANDOM_ITEMS / 2)
            begin
                in_ch.valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            r       = $urandom_range(0, 199);
            restart = (r < 6) || ($urandom_range(0, 99) == 0);
            r       = $urandom_range(0, 99);
            if (r < 88)
                kind = slse_pkg::KIND_FINITE;
            else if (r < 91)
                kind = slse_pkg::KIND_POS_INF;
            else if (r < 97)
                kind = KIND_NEG_INF;
            else
                kind = KIND_UNUSED;
            send_request(random_sample(model_peak), kind, restart, 1'b0, none);
        end

        in_ch.valid = 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40)
            @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
